// ===== sv/burning_ship_escape_time_assert.svh =====
// ----------------------------------------------------------------------------
// burning ship assertion macros
// shared concurrent assertion forms for the escape-time engine
// ----------------------------------------------------------------------------
`ifndef BURNING_SHIP_ESCAPE_TIME_ASSERT_SVH
`define BURNING_SHIP_ESCAPE_TIME_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BSHIP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BSHIP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bship_pkg.sv =====
// ----------------------------------------------------------------------------
// bship_pkg
// types, constants and helpers shared by the burning ship escape-time engine
// ----------------------------------------------------------------------------
package bship_pkg;

    // fixed point format, signed q4.28
    localparam int FRAC_BITS = 28;
    localparam int Q_W       = 32;
    // truncated square and cross product width
    localparam int SQ_W      = 36;

    // escape bound 4.0 in unsigned q9.28
    localparam logic [SQ_W:0] ESC_BOUND = (SQ_W + 1)'(64'd1 << 30);

    // configuration reset values
    localparam logic signed [31:0] OFFSET_RESET = 32'sd0;
    localparam logic [28:0]        STEP_RESET   = 29'd2097152;
    localparam logic [15:0]        LIMIT_RESET  = 16'd100;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_OFF_RE = 2'd0,
        CFG_OFF_IM = 2'd1,
        CFG_STEP   = 2'd2,
        CFG_LIMIT  = 2'd3
    } t_cfg_idx;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMUL,
        ST_CADD,
        ST_ZMUL,
        ST_EVAL,
        ST_FIN
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic cmul;
        logic cadd;
        logic zmul;
        logic step;
        logic inc;
        logic set_esc;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic limit_zero;
        logic escape;
        logic last;
    } t_sts;

    // magnitude of a q4.28 value, exact for the most negative code
    function automatic logic [Q_W-1:0] mag_q(input logic signed [Q_W-1:0] v);
        logic [Q_W-1:0] m;
        m = v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
        return m;
    endfunction

endpackage

// ===== sv/bship_dp.sv =====
// ----------------------------------------------------------------------------
// bship_dp
// datapath: point mapping, squaring unit, z update, escape test, result regs
// ----------------------------------------------------------------------------
module bship_dp #(
    parameter int IMAGE_SIZE = 512
) (
    input  logic                 i_clk,
    input  bship_pkg::t_cmd      i_cmd,
    output bship_pkg::t_sts      o_sts,
    input  logic [8:0]           i_pixel_x,
    input  logic [8:0]           i_pixel_y,
    input  logic signed [31:0]   i_offset_real,
    input  logic signed [31:0]   i_offset_imag,
    input  logic [28:0]          i_pixel_step,
    input  logic [15:0]          i_iteration_limit,
    output logic [8:0]           o_out_x,
    output logic [8:0]           o_out_y,
    output logic [15:0]          o_iteration_count,
    output logic                 o_escaped
);

    localparam int HALF = IMAGE_SIZE / 2;
    localparam int HW   = $clog2(HALF) + 2;
    // pixel offset width, wide enough for the pixel code and for half the image
    localparam int DW   = (HW > 10) ? HW : 10;
    localparam int PW   = DW + 30;
    localparam int CW   = PW + 1;
    localparam int UW   = CW + 2;
    localparam int QW   = bship_pkg::Q_W;
    localparam int SW   = bship_pkg::SQ_W;
    localparam int FB   = bship_pkg::FRAC_BITS;

    localparam logic signed [DW-1:0] HALF_D = DW'(HALF);
    localparam logic signed [UW-1:0] Q_MAX  = UW'(64'sh7fff_ffff);
    localparam logic signed [UW-1:0] Q_MIN  = UW'(-64'sh8000_0000);

    // clamp to the q4.28 range
    function automatic logic signed [QW-1:0] sat_q(input logic signed [UW-1:0] v);
        logic signed [QW-1:0] r;
        if (v > Q_MAX) begin
            r = QW'(Q_MAX);
        end else if (v < Q_MIN) begin
            r = QW'(Q_MIN);
        end else begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

    logic [8:0]              r_px;
    logic [8:0]              r_py;
    logic signed [PW-1:0]    r_cpr;
    logic signed [PW-1:0]    r_cpi;
    logic signed [CW-1:0]    r_cr;
    logic signed [CW-1:0]    r_ci;
    logic signed [QW-1:0]    r_zr;
    logic signed [QW-1:0]    r_zi;
    logic [SW-1:0]           r_sx;
    logic [SW-1:0]           r_sy;
    logic [SW-1:0]           r_cross;
    logic [15:0]             r_n;
    logic                    r_esc;
    logic [8:0]              r_out_x;
    logic [8:0]              r_out_y;
    logic [15:0]             r_out_cnt;
    logic                    r_out_esc;

    logic signed [DW-1:0]    w_dx;
    logic signed [DW-1:0]    w_dy;
    logic signed [PW-1:0]    w_step_s;
    logic signed [CW-1:0]    w_cr_sum;
    logic signed [CW-1:0]    w_ci_sum;
    logic [QW-1:0]           w_ax;
    logic [QW-1:0]           w_ay;
    logic [63:0]             w_pxx;
    logic [63:0]             w_pyy;
    logic [63:0]             w_pxy;
    logic signed [UW-1:0]    w_zr_sum;
    logic signed [UW-1:0]    w_zi_sum;
    logic [SW:0]             w_mag2;
    logic [16:0]             w_n_inc;

    // pixel offsets from the image center
    assign w_dx     = $signed({{(DW-9){1'b0}}, r_px}) - HALF_D;
    assign w_dy     = $signed({{(DW-9){1'b0}}, r_py}) - HALF_D;
    assign w_step_s = PW'($signed({1'b0, i_pixel_step}));

    // point c, kept at full width
    assign w_cr_sum = CW'(r_cpr) + CW'(i_offset_real);
    assign w_ci_sum = CW'(r_cpi) + CW'(i_offset_imag);

    // squaring unit on the folded z
    assign w_ax  = bship_pkg::mag_q(r_zr);
    assign w_ay  = bship_pkg::mag_q(r_zi);
    assign w_pxx = 64'(w_ax) * 64'(w_ax);
    assign w_pyy = 64'(w_ay) * 64'(w_ay);
    assign w_pxy = 64'(w_ax) * 64'(w_ay);

    // z update from the registered products
    assign w_zr_sum = UW'($signed({1'b0, r_sx})) - UW'($signed({1'b0, r_sy})) + UW'(r_cr);
    assign w_zi_sum = UW'($signed({1'b0, r_cross})) + UW'(r_ci);

    // escape test and loop bound
    assign w_mag2  = {1'b0, r_sx} + {1'b0, r_sy};
    assign w_n_inc = {1'b0, r_n} + 17'd1;

    assign o_sts.limit_zero = (i_iteration_limit == 16'd0);
    assign o_sts.escape     = (w_mag2 >= bship_pkg::ESC_BOUND);
    assign o_sts.last       = (w_n_inc >= {1'b0, i_iteration_limit});

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
        end
        if (i_cmd.cmul) begin
            r_cpr <= PW'(w_dx) * w_step_s;
            r_cpi <= PW'(w_dy) * w_step_s;
        end
        if (i_cmd.cadd) begin
            r_cr  <= w_cr_sum;
            r_ci  <= w_ci_sum;
            r_zr  <= sat_q(UW'(w_cr_sum));
            r_zi  <= sat_q(UW'(w_ci_sum));
            r_n   <= 16'd0;
            r_esc <= 1'b0;
        end
        if (i_cmd.zmul) begin
            r_sx    <= w_pxx[FB+SW-1:FB];
            r_sy    <= w_pyy[FB+SW-1:FB];
            r_cross <= w_pxy[FB+SW-2:FB-1];
        end
        if (i_cmd.step) begin
            r_zr <= sat_q(w_zr_sum);
            r_zi <= sat_q(w_zi_sum);
        end
        if (i_cmd.step || i_cmd.inc) begin
            r_n <= w_n_inc[15:0];
        end
        if (i_cmd.set_esc) begin
            r_esc <= 1'b1;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_x   <= r_px;
            r_out_y   <= r_py;
            r_out_cnt <= r_n;
            r_out_esc <= r_esc;
        end
    end

    assign o_out_x           = r_out_x;
    assign o_out_y           = r_out_y;
    assign o_iteration_count = r_out_cnt;
    assign o_escaped         = r_out_esc;

endmodule

// ===== sv/bship_ctrl.sv =====
// ----------------------------------------------------------------------------
// bship_ctrl
// sequencer for one pixel at a time and the output word valid flag
// ----------------------------------------------------------------------------
`include "burning_ship_escape_time_assert.svh"

module bship_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    input  bship_pkg::t_sts    i_sts,
    output bship_pkg::t_cmd    o_cmd
);

    bship_pkg::t_state r_state;
    bship_pkg::t_state n_state;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_out_free;

    // output slot is free when empty or being taken
    assign w_out_free = !r_out_valid || !i_stall;

    // state and valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bship_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            bship_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bship_pkg::ST_CMUL;
                end
            end
            bship_pkg::ST_CMUL: begin
                o_cmd.cmul = 1'b1;
                n_state    = bship_pkg::ST_CADD;
            end
            bship_pkg::ST_CADD: begin
                o_cmd.cadd = 1'b1;
                n_state    = i_sts.limit_zero ? bship_pkg::ST_FIN : bship_pkg::ST_ZMUL;
            end
            bship_pkg::ST_ZMUL: begin
                o_cmd.zmul = 1'b1;
                n_state    = bship_pkg::ST_EVAL;
            end
            bship_pkg::ST_EVAL: begin
                if (i_sts.escape) begin
                    o_cmd.set_esc = 1'b1;
                    n_state       = bship_pkg::ST_FIN;
                end else if (i_sts.last) begin
                    o_cmd.inc = 1'b1;
                    n_state   = bship_pkg::ST_FIN;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = bship_pkg::ST_ZMUL;
                end
            end
            bship_pkg::ST_FIN: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = bship_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bship_pkg::ST_IDLE;
            end
        endcase
    end

    // output valid tracking
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_stall = (r_state != bship_pkg::ST_IDLE);
    assign o_valid = r_out_valid;

    // checks
    `BSHIP_ASSERT_IMP(a_out_slot_free, i_clk, i_rst_n, o_cmd.out_load, w_out_free, "result loaded over a pending word")
    `BSHIP_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall && r_state == bship_pkg::ST_CMUL, "accept did not start the mapping")
    `BSHIP_ASSERT_IMP(a_step_only_inside, i_clk, i_rst_n, o_cmd.step, !i_sts.escape && !i_sts.last, "update issued past escape or limit")
    `BSHIP_ASSERT_NXT(a_result_posted, i_clk, i_rst_n, o_cmd.out_load, r_out_valid && r_state == bship_pkg::ST_IDLE, "result not posted after load")

endmodule

// ===== sv/burning_ship_escape_time.sv =====
// flow: accept loads the pixel, then mapping multiply, offset add, and a square-then-test loop
// over z (1..limit values tested); a zero iteration limit skips the loop after the offset add
// the result waits in the finish state while a pending output word is stalled; pixels go one at a time,
// and a new pixel is taken once the previous result sits in the output register
// reset: synchronous active low, clears the sequencer and valid, loads register defaults
// ----------------------------------------------------------------------------
// burning_ship_escape_time
// burning ship escape-time engine: config registers, sequencer and datapath
// ----------------------------------------------------------------------------
module burning_ship_escape_time #(
    parameter int IMAGE_SIZE = 512
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [8:0]   i_pixel_x,
    input  logic [8:0]   i_pixel_y,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [8:0]   o_out_x,
    output logic [8:0]   o_out_y,
    output logic [15:0]  o_iteration_count,
    output logic         o_escaped
);

    logic signed [31:0] r_offset_real;
    logic signed [31:0] r_offset_imag;
    logic [28:0]        r_pixel_step;
    logic [15:0]        r_iteration_limit;

    bship_pkg::t_cmd    w_cmd;
    bship_pkg::t_sts    w_sts;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_real     <= bship_pkg::OFFSET_RESET;
            r_offset_imag     <= bship_pkg::OFFSET_RESET;
            r_pixel_step      <= bship_pkg::STEP_RESET;
            r_iteration_limit <= bship_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bship_pkg::CFG_OFF_RE: r_offset_real     <= $signed(i_cfg_data);
                bship_pkg::CFG_OFF_IM: r_offset_imag     <= $signed(i_cfg_data);
                bship_pkg::CFG_STEP:   r_pixel_step      <= i_cfg_data[28:0];
                bship_pkg::CFG_LIMIT:  r_iteration_limit <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    bship_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // arithmetic
    bship_dp #(
        .IMAGE_SIZE (IMAGE_SIZE)
    ) u_dp (
        .i_clk             (i_clk),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_pixel_x         (i_pixel_x),
        .i_pixel_y         (i_pixel_y),
        .i_offset_real     (r_offset_real),
        .i_offset_imag     (r_offset_imag),
        .i_pixel_step      (r_pixel_step),
        .i_iteration_limit (r_iteration_limit),
        .o_out_x           (o_out_x),
        .o_out_y           (o_out_y),
        .o_iteration_count (o_iteration_count),
        .o_escaped         (o_escaped)
    );

endmodule
